>>> src/kickstand_alarm_controller_unit_macros.svh
// assertion macros for the kickstand alarm controller
// used by the checker module, no other dependencies
`ifndef KICKSTAND_ALARM_CONTROLLER_UNIT_MACROS_SVH
`define KICKSTAND_ALARM_CONTROLLER_UNIT_MACROS_SVH

// concurrent assertion with explicit clock and active-low reset
`define KAC_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("kac assertion failed");

// same, on the usual clk_i and rst_ni
`define KAC_ASSERT(lbl, prop) \
  `KAC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> src/kac_pkg.sv
// shared types and constants for the kickstand alarm controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kac_pkg;

  localparam int unsigned QualW        = 8;
  localparam int unsigned BeepW        = 16;
  localparam int unsigned TimeoutW     = 24;
  localparam int unsigned CfgW         = 24;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned TimerBitsDef = 24;

  localparam logic [CfgIdxW-1:0] CfgQualify = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBeep    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout = 2'd2;

  localparam logic [QualW-1:0]    QualifyRst = 8'd20;
  localparam logic [BeepW-1:0]    BeepRst    = 16'd1000;
  localparam logic [TimeoutW-1:0] TimeoutRst = 24'd120000;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_WPRESS = 3'd1,
    MODE_WDOWN  = 3'd2,
    MODE_WREL   = 3'd3,
    MODE_ARMED  = 3'd4,
    MODE_TRIG   = 3'd5,
    MODE_SIL    = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_GREEN = 2'd1,
    LED_RED   = 2'd2
  } led_e;

  typedef struct packed {
    mode_e mode;
    logic  siren;
    led_e  led;
    logic  latched;
    logic  btn;
    logic  kick;
  } result_t;

endpackage

`default_nettype wire

>>> src/kac_qual.sv
// consecutive-sample qualifier for one active-low switch
// depends on kac_pkg
`timescale 1ns / 1ps
`default_nettype none

module kac_qual
  import kac_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             level_i,
  input  wire logic [QualW-1:0] qualify_i,
  output logic                  closed_o
);

  logic [QualW-1:0] run_q, run_d, qual_eff;

  always_comb begin
    if (level_i) begin
      run_d = '0;
    end else if (run_q == {QualW{1'b1}}) begin
      run_d = run_q;
    end else begin
      run_d = run_q + 1'b1;
    end
    qual_eff = (qualify_i == '0) ? QualW'(1) : qualify_i;
  end

  assign closed_o = (run_d >= qual_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (step_i) begin
      run_q <= run_d;
    end
  end

endmodule

`default_nettype wire

>>> src/kac_fsm.sv
// arming and alarm state machine with elapsed and beep timers
// depends on kac_pkg
`timescale 1ns / 1ps
`default_nettype none

module kac_fsm
  import kac_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                btn_i,
  input  wire logic                kick_i,
  input  wire logic [BeepW-1:0]    beep_half_i,
  input  wire logic [TimeoutW-1:0] timeout_i,
  output result_t                  res_o
);

  localparam int unsigned CmpW = (TIMER_BITS > TimeoutW) ? TIMER_BITS : TimeoutW;

  mode_e                 mode_q, mode_d, next_mode;
  led_e                  led_q, led_d;
  logic                  siren_q, siren_d, latched_q, latched_d, take;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [BeepW-1:0]      beep_q, beep_d, hp_eff;
  logic [BeepW:0]        beep_sum;
  logic [CmpW-1:0]       el_ext, to_ext;
  logic                  timed_out;

  always_comb begin
    elapsed_inc = (elapsed_q == {TIMER_BITS{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
    el_ext      = CmpW'(elapsed_inc);
    to_ext      = CmpW'(timeout_i);
    timed_out   = (el_ext >= to_ext);
    hp_eff      = (beep_half_i == '0) ? BeepW'(1) : beep_half_i;
    beep_sum    = {1'b0, beep_q} + 1'b1;
  end

  // transitions in priority order
  always_comb begin
    take      = 1'b0;
    next_mode = mode_q;
    case (mode_q)
      MODE_START: begin
        take      = 1'b1;
        next_mode = latched_q ? MODE_TRIG : MODE_WPRESS;
      end
      MODE_WPRESS: begin
        if (btn_i) begin
          take = 1'b1; next_mode = MODE_WDOWN;
        end
      end
      MODE_WDOWN: begin
        if (!btn_i) begin
          take = 1'b1; next_mode = MODE_WPRESS;
        end else if (kick_i) begin
          take = 1'b1; next_mode = MODE_WREL;
        end
      end
      MODE_WREL: begin
        if (!kick_i) begin
          take = 1'b1; next_mode = MODE_WDOWN;
        end else if (!btn_i) begin
          take = 1'b1; next_mode = MODE_ARMED;
        end
      end
      MODE_ARMED: begin
        if (!kick_i) begin
          take = 1'b1; next_mode = MODE_TRIG;
        end else if (btn_i) begin
          take = 1'b1; next_mode = MODE_WREL;
        end
      end
      MODE_TRIG: begin
        if (btn_i && kick_i) begin
          take = 1'b1; next_mode = MODE_SIL;
        end else if (kick_i && timed_out) begin
          take = 1'b1; next_mode = MODE_ARMED;
        end
      end
      default: begin
        if (!kick_i) begin
          take = 1'b1; next_mode = MODE_WDOWN;
        end else if (!btn_i) begin
          take = 1'b1; next_mode = MODE_TRIG;
        end
      end
    endcase
  end

  // entry actions, elapsed timer and beep timer
  always_comb begin
    mode_d    = mode_q;
    led_d     = led_q;
    siren_d   = siren_q;
    latched_d = latched_q;
    beep_d    = beep_q;
    elapsed_d = elapsed_inc;
    if (take) begin
      if (mode_q == MODE_SIL) begin
        siren_d   = 1'b0;
        latched_d = 1'b0;
      end
      mode_d    = next_mode;
      elapsed_d = '0;
      case (next_mode)
        MODE_START: begin
          latched_d = 1'b0;
          led_d     = LED_GREEN;
        end
        MODE_WPRESS: led_d = LED_OFF;
        MODE_WDOWN:  led_d = LED_GREEN;
        MODE_WREL:   led_d = LED_RED;
        MODE_ARMED: begin
          led_d   = LED_OFF;
          siren_d = 1'b0;
        end
        MODE_TRIG: begin
          siren_d   = 1'b1;
          latched_d = 1'b1;
          led_d     = LED_OFF;
          beep_d    = '0;
        end
        default: led_d = LED_RED;
      endcase
    end else if (mode_q == MODE_TRIG) begin
      if (beep_sum >= {1'b0, hp_eff}) begin
        beep_d  = '0;
        siren_d = ~siren_q;
      end else begin
        beep_d = beep_sum[BeepW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_START;
      led_q     <= LED_GREEN;
      siren_q   <= 1'b0;
      latched_q <= 1'b0;
      beep_q    <= '0;
      elapsed_q <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      led_q     <= led_d;
      siren_q   <= siren_d;
      latched_q <= latched_d;
      beep_q    <= beep_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_comb begin
    res_o.mode    = mode_d;
    res_o.siren   = siren_d;
    res_o.led     = led_d;
    res_o.latched = latched_d;
    res_o.btn     = btn_i;
    res_o.kick    = kick_i;
  end

endmodule

`default_nettype wire

>>> src/kickstand_alarm_controller_unit.sv
// kickstand alarm controller top level: input register, qualifiers, state machine
// and result register; depends on kac_pkg, kac_qual and kac_fsm
//
// usage
//   input channel: in_valid_i / in_stall_o carry one tick item (raw active-low
//   button and kickstand levels); an item is taken when valid is high and
//   stall is low
//   output channel: out_valid_o / out_stall_i carry one result item per tick
//   item: mode, siren, led colour, latch and both qualified switch states
//   flow: items go from the input register through the qualifiers and state
//   machine to the result register; one item per cycle unless the output stalls
//   config: cfg_we_i writes cfg_wdata_i to register cfg_index_i (0 qualify,
//   1 beep half period, 2 silence timeout); the user must write only while
//   the block is idle; the block itself does not enforce this
//   reset: start mode, led green, siren off, latch clear, run counters zero,
//   registers at 20 / 1000 / 120000; no clearing pass, ready at once
//   stall: a stalled result holds; one further item waits in the input
//   register, after which in_stall_o rises until the result is taken
`timescale 1ns / 1ps
`default_nettype none

module kickstand_alarm_controller_unit
  import kac_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               button_level_i,
  input  wire logic               kickstand_level_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              mode_code_o,
  output logic                    siren_on_o,
  output logic [1:0]              led_colour_o,
  output logic                    alarm_latched_o,
  output logic                    button_pressed_o,
  output logic                    kickstand_down_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  logic [QualW-1:0]    qualify_q;
  logic [BeepW-1:0]    beep_half_q;
  logic [TimeoutW-1:0] timeout_q;

  logic    in_valid_q, btn_lvl_q, kick_lvl_q;
  logic    out_valid_q;
  logic    advance, step, in_load, btn, kick;
  result_t res, res_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_load    = !in_valid_q || advance;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qualify_q   <= QualifyRst;
      beep_half_q <= BeepRst;
      timeout_q   <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgQualify: qualify_q   <= cfg_wdata_i[QualW-1:0];
        CfgBeep:    beep_half_q <= cfg_wdata_i[BeepW-1:0];
        CfgTimeout: timeout_q   <= cfg_wdata_i[TimeoutW-1:0];
        default:    ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      btn_lvl_q  <= button_level_i;
      kick_lvl_q <= kickstand_level_i;
    end
  end

  kac_qual u_btn_qual (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .level_i   (btn_lvl_q),
    .qualify_i (qualify_q),
    .closed_o  (btn)
  );

  kac_qual u_kick_qual (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .level_i   (kick_lvl_q),
    .qualify_i (qualify_q),
    .closed_o  (kick)
  );

  kac_fsm #(
    .TIMER_BITS (TIMER_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .btn_i       (btn),
    .kick_i      (kick),
    .beep_half_i (beep_half_q),
    .timeout_i   (timeout_q),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_code_o      = res_q.mode;
  assign siren_on_o       = res_q.siren;
  assign led_colour_o     = res_q.led;
  assign alarm_latched_o  = res_q.latched;
  assign button_pressed_o = res_q.btn;
  assign kickstand_down_o = res_q.kick;

endmodule

`default_nettype wire

>>> src/kac_checker.sv
// port-level checks for the kickstand alarm controller, bound to the top level
// depends on kac_pkg and kickstand_alarm_controller_unit_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "kickstand_alarm_controller_unit_macros.svh"

module kac_checker
  import kac_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_stall_i,
  input wire logic [2:0] mode_code_i,
  input wire logic       siren_on_i,
  input wire logic [1:0] led_colour_i,
  input wire logic       alarm_latched_i
);

  // held result item keeps valid and its mode
  `KAC_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i && $stable(mode_code_i))

  // siren is always quiet once armed
  `KAC_ASSERT(a_armed_quiet, out_valid_i && mode_code_i == MODE_ARMED |-> !siren_on_i)

  // triggered always shows the latch set and the light off
  `KAC_ASSERT(a_trig_latch, out_valid_i && mode_code_i == MODE_TRIG |-> alarm_latched_i && led_colour_i == LED_OFF)

  // waiting for release and silencing show red
  `KAC_ASSERT(a_red_modes, out_valid_i && (mode_code_i == MODE_WREL || mode_code_i == MODE_SIL) |-> led_colour_i == LED_RED)

endmodule

bind kickstand_alarm_controller_unit kac_checker u_kac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .mode_code_i     (mode_code_o),
  .siren_on_i      (siren_on_o),
  .led_colour_i    (led_colour_o),
  .alarm_latched_i (alarm_latched_o)
);

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the kickstand alarm controller: drives tick items, predicts every status item
// and checks it field by field; needs kac_pkg and kickstand_alarm_controller_unit only
`timescale 1ns / 1ps

module tb;
  import kac_pkg::*;

  class alarm_status_board;
    logic [QualW-1:0]        qualify;
    logic [BeepW-1:0]        beep_half;
    logic [TimeoutW-1:0]     quiet_limit;
    mode_e                   mode;
    logic [TimerBitsDef-1:0] elapsed;
    logic [BeepW-1:0]        beep_count;
    logic                    siren;
    logic                    latched;
    logic [7:0]              btn_run;
    logic [7:0]              kick_run;
    led_e                    led;
    result_t                 status_due[$];
    int                      mismatches;

    function new();
      qualify     = QualifyRst;
      beep_half   = BeepRst;
      quiet_limit = TimeoutRst;
      mode        = MODE_START;
      elapsed     = '0;
      beep_count  = '0;
      siren       = 1'b0;
      latched     = 1'b0;
      btn_run     = 8'd0;
      kick_run    = 8'd0;
      led         = LED_GREEN;
      mismatches  = 0;
    endfunction

    function void enter(mode_e nxt);
      if (mode == MODE_SIL) begin
        siren   = 1'b0;
        latched = 1'b0;
      end
      mode    = nxt;
      elapsed = '0;
      case (nxt)
        MODE_START: begin
          latched = 1'b0;
          led     = LED_GREEN;
        end
        MODE_WPRESS: led = LED_OFF;
        MODE_WDOWN:  led = LED_GREEN;
        MODE_WREL:   led = LED_RED;
        MODE_ARMED: begin
          led   = LED_OFF;
          siren = 1'b0;
        end
        MODE_TRIG: begin
          siren      = 1'b1;
          latched    = 1'b1;
          led        = LED_OFF;
          beep_count = '0;
        end
        default: led = LED_RED;
      endcase
    endfunction

    function logic [7:0] run_step(logic [7:0] run, logic level);
      if (level) return 8'd0;
      return (run == 8'hff) ? run : run + 8'd1;
    endfunction

    function void note_tick(logic b_level, logic k_level);
      logic [QualW-1:0] q;
      logic [BeepW-1:0] hp;
      logic             btn;
      logic             kick;
      logic             moves;
      mode_e            nxt;
      result_t          r;
      q        = (qualify == '0) ? 8'd1 : qualify;
      hp       = (beep_half == '0) ? 16'd1 : beep_half;
      btn_run  = run_step(btn_run, b_level);
      kick_run = run_step(kick_run, k_level);
      btn      = btn_run >= q;
      kick     = kick_run >= q;
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      moves = 1'b1;
      nxt   = mode;
      case (mode)
        MODE_START:  nxt = latched ? MODE_TRIG : MODE_WPRESS;
        MODE_WPRESS: if (btn) nxt = MODE_WDOWN; else moves = 1'b0;
        MODE_WDOWN: begin
          if (!btn) nxt = MODE_WPRESS;
          else if (kick) nxt = MODE_WREL;
          else moves = 1'b0;
        end
        MODE_WREL: begin
          if (!kick) nxt = MODE_WDOWN;
          else if (!btn) nxt = MODE_ARMED;
          else moves = 1'b0;
        end
        MODE_ARMED: begin
          if (!kick) nxt = MODE_TRIG;
          else if (btn) nxt = MODE_WREL;
          else moves = 1'b0;
        end
        MODE_TRIG: begin
          if (btn && kick) nxt = MODE_SIL;
          else if (kick && elapsed >= quiet_limit) nxt = MODE_ARMED;
          else moves = 1'b0;
        end
        default: begin
          if (!kick) nxt = MODE_WDOWN;
          else if (!btn) nxt = MODE_TRIG;
          else moves = 1'b0;
        end
      endcase
      if (moves) begin
        enter(nxt);
      end else if (mode == MODE_TRIG) begin
        beep_count = beep_count + 1'b1;
        if (beep_count >= hp) begin
          beep_count = '0;
          siren      = ~siren;
        end
      end
      r.mode    = mode;
      r.siren   = siren;
      r.led     = led;
      r.latched = latched;
      r.btn     = btn;
      r.kick    = kick;
      status_due.push_back(r);
    endfunction

    task flag_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_status(result_t got);
      result_t want;
      if (status_due.size() == 0) begin
        flag_mismatch($sformatf("status item with none due, mode %0d", got.mode));
        return;
      end
      want = status_due.pop_front();
      if (got.mode !== want.mode)
        flag_mismatch($sformatf("mode_code got %0d want %0d", got.mode, want.mode));
      if (got.siren !== want.siren)
        flag_mismatch($sformatf("siren_on got %0b want %0b", got.siren, want.siren));
      if (got.led !== want.led)
        flag_mismatch($sformatf("led_colour got %0d want %0d", got.led, want.led));
      if (got.latched !== want.latched)
        flag_mismatch($sformatf("alarm_latched got %0b want %0b", got.latched, want.latched));
      if (got.btn !== want.btn)
        flag_mismatch($sformatf("button_pressed got %0b want %0b", got.btn, want.btn));
      if (got.kick !== want.kick)
        flag_mismatch($sformatf("kickstand_down got %0b want %0b", got.kick, want.kick));
    endtask
  endclass

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               in_valid_i        = 1'b0;
  logic               in_stall_o;
  logic               button_level_i    = 1'b1;
  logic               kickstand_level_i = 1'b1;
  logic               out_valid_o;
  logic               out_stall_i       = 1'b0;
  logic [2:0]         mode_code_o;
  logic               siren_on_o;
  logic [1:0]         led_colour_o;
  logic               alarm_latched_o;
  logic               button_pressed_o;
  logic               kickstand_down_o;
  logic               cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i       = CfgQualify;
  logic [CfgW-1:0]    cfg_wdata_i       = '0;

  logic               calm              = 1'b0;
  int                 ticks_sent        = 0;
  alarm_status_board  board;

  kickstand_alarm_controller_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .button_level_i    (button_level_i),
    .kickstand_level_i (kickstand_level_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mode_code_o       (mode_code_o),
    .siren_on_o        (siren_on_o),
    .led_colour_o      (led_colour_o),
    .alarm_latched_o   (alarm_latched_o),
    .button_pressed_o  (button_pressed_o),
    .kickstand_down_o  (kickstand_down_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : watch
    result_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.mode    = mode_e'(mode_code_o);
        seen.siren   = siren_on_o;
        seen.led     = led_e'(led_colour_o);
        seen.latched = alarm_latched_o;
        seen.btn     = button_pressed_o;
        seen.kick    = kickstand_down_o;
        board.check_status(seen);
      end
      if (in_valid_i && !in_stall_o) board.note_tick(button_level_i, kickstand_level_i);
    end
  end

  initial begin : stall_gen
    forever begin
      out_stall_i <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(posedge clk_i);
      if (!calm) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  task automatic send_tick(logic b, logic k);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    button_level_i    <= b;
    kickstand_level_i <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic hold(logic b, logic k, int n);
    repeat (n) send_tick(b, k);
  endtask

  function automatic int span();
    int q;
    q = (board.qualify == '0) ? 1 : int'(board.qualify);
    if ($urandom_range(0, 6) == 0) return $urandom_range(1, q);
    return q + $urandom_range(0, 3);
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [QualW-1:0] q, logic [BeepW-1:0] hp,
                              logic [TimeoutW-1:0] quiet);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgQualify;
    cfg_wdata_i <= CfgW'(q);
    @(posedge clk_i);
    board.qualify = q;
    cfg_index_i   <= CfgBeep;
    cfg_wdata_i   <= CfgW'(hp);
    @(posedge clk_i);
    board.beep_half = hp;
    cfg_index_i     <= CfgTimeout;
    cfg_wdata_i     <= CfgW'(quiet);
    @(posedge clk_i);
    board.quiet_limit = quiet;
    cfg_we_i          <= 1'b0;
  endtask

  // press, kickstand down, release to arm, lift to trigger, then one way out
  task automatic arming_run();
    int way;
    way = $urandom_range(0, 2);
    hold(1'b0, 1'b1, span());
    hold(1'b0, 1'b0, span());
    hold(1'b1, 1'b0, span() + $urandom_range(0, 4));
    hold(1'b1, 1'b1, span() + $urandom_range(0, 12));
    case (way)
      0: begin
        hold(1'b0, 1'b0, span());
        hold(1'b1, 1'b0, span() + $urandom_range(0, 50));
      end
      1: begin
        hold(1'b0, 1'b0, span());
        hold(1'b0, 1'b1, span());
      end
      default: hold(1'b1, 1'b0, span() + $urandom_range(0, 50));
    endcase
  endtask

  task automatic noise_burst();
    if ($urandom_range(0, 1) == 0)
      repeat ($urandom_range(1, 12))
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else
      hold(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), span());
  endtask

  task automatic random_phase(int budget);
    int stop_at;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) noise_burst();
      else arming_run();
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, all level pairs
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    settle();

    // zero qualify and zero half period act as one
    program_regs(8'd0, 16'd0, 24'd3);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    hold(1'b1, 1'b1, 3);
    send_tick(1'b0, 1'b0);
    hold(1'b1, 1'b0, 4);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    hold(1'b0, 1'b0, 2);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();

    program_regs(8'd1, 16'd1, 24'd5);
    random_phase(350);
    settle();

    program_regs(8'd3, 16'd2, 24'd40);
    random_phase(400);
    settle();

    // widest settings, run counters saturate
    program_regs(8'd255, 16'hffff, 24'hffffff);
    hold(1'b1, 1'b1, 20);
    hold(1'b0, 1'b1, 270);
    hold(1'b0, 1'b0, 260);
    hold(1'b1, 1'b0, 40);
    settle();

    program_regs(8'd2, 16'd3, 24'd0);
    random_phase(250);
    settle();

    calm = 1'b1;
    program_regs(8'd4, 16'd5, 24'd60);
    random_phase(300);
    settle();

    if (board.mismatches == 0)
      $display("kickstand_alarm_controller_unit test passed");
    else
      $display("kickstand_alarm_controller_unit test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("kickstand_alarm_controller_unit test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/kac_pkg.sv
src/kac_qual.sv
src/kac_fsm.sv
src/kickstand_alarm_controller_unit.sv
src/kac_checker.sv
tb/sv/tb.sv
